// ===== design/mgst_pkg.sv =====
// ---------------------------------------------------------------------------
// mgst_pkg
// Shared sizes, codes and types for the multiset GCD segment tree.
// ---------------------------------------------------------------------------
package mgst_pkg;

  localparam int CAPACITY = 1024;
  localparam int VAL_W    = 31;
  localparam int LVL      = $clog2(CAPACITY);
  localparam int NODE_W   = LVL + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  localparam logic MODE_INS = 1'b0;
  localparam logic MODE_DEL = 1'b1;

  // GCD unit handshake
  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } gcd_req_t;

  typedef struct packed {
    logic done;
    val_t g;
  } gcd_rsp_t;

endpackage

// ===== design/multiset_gcd_segment_tree_top.sv =====
// ---------------------------------------------------------------------------
// multiset_gcd_segment_tree_top
// Multiset of values under a GCD tree; each beat returns the overall GCD.
// ---------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)                 handshake
// in_      in   mode[0], value[31:1]                       tvalid/tready
// out_     out  gcd_all[30:0], status[32:31], zero pad     tvalid/tready
//
// Insert: LVL levels, each a node write with a sibling read plus a binary GCD
// of the two children. Delete adds a slot scan, one slot read per slot, and
// up to two path updates: clear the last slot, move it into the found slot.
// After reset a clearing pass writes zero over all 2*CAPACITY nodes, one a
// cycle, before the first input beat is taken. in_tready is low while an item
// is in work and while a result waits in the output register for out_tready.
// ---------------------------------------------------------------------------
module multiset_gcd_segment_tree_top import mgst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // mode[0], value[31:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // gcd_all[30:0], status[32:31]
);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_SCANW = 10'b0000001000,
    S_LEAF  = 10'b0000010000,
    S_RDL   = 10'b0000100000,
    S_RDW   = 10'b0001000000,
    S_GCD   = 10'b0010000000,
    S_ROOT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  val_t   mem [2*CAPACITY];
  val_t   rd_r;
  node_t  raddr;
  logic   wen;
  node_t  waddr;
  val_t   wdata;

  val_t    val_r, val_nxt;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    idx_r, idx_nxt;
  node_t   node_r, node_nxt;
  val_t    lft_r, lft_nxt;
  val_t    moved_r, moved_nxt;
  cnt_t    pos_r, pos_nxt;
  logic    second_r, second_nxt;   // second path pending (move into pos)
  status_t st_r, st_nxt;
  val_t    gout_r, gout_nxt;
  logic    ov_r, ov_nxt;
  node_t   clr_r, clr_nxt;
  gcd_req_t greq;
  gcd_rsp_t grsp;

  mgst_gcd u_gcd (.clk(clk), .rst_n(rst_n), .req(greq), .rsp(grsp));

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign in_tready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    node_nxt   = node_r;
    lft_nxt    = lft_r;
    moved_nxt  = moved_r;
    pos_nxt    = pos_r;
    second_nxt = second_r;
    st_nxt     = st_r;
    gout_nxt   = gout_r;
    ov_nxt     = ov_r;
    clr_nxt    = clr_r;
    raddr      = node_r;
    wen        = 1'b0;
    waddr      = node_r;
    wdata      = '0;
    greq       = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        wen     = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == node_t'(2*CAPACITY-1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          val_nxt    = in_tdata[31:1];
          st_nxt     = ST_OK;
          second_nxt = 1'b0;
          idx_nxt    = '0;
          if (in_tdata[0] == MODE_INS) begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              st_nxt    = ST_FULL;
              state_nxt = S_ROOT;
            end else begin
              node_nxt  = node_t'(CAPACITY) + node_t'(cnt_r);
              lft_nxt   = in_tdata[31:1];
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_LEAF;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one slot read per pass
        if (idx_r == cnt_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_ROOT;
        end else begin
          raddr     = node_t'(CAPACITY) + node_t'(idx_r);
          state_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        if (rd_r == val_r) begin
          pos_nxt   = idx_r;
          raddr     = node_t'(CAPACITY) + node_t'(cnt_r - 1'b1);
          node_nxt  = node_t'(CAPACITY) + node_t'(cnt_r - 1'b1);
          state_nxt = S_RDW;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_RDW: begin
        // capture the moved value, then clear the last slot
        moved_nxt  = rd_r;
        second_nxt = (pos_r != cnt_r - 1'b1);
        cnt_nxt    = cnt_r - 1'b1;
        lft_nxt    = '0;
        state_nxt  = S_LEAF;
      end
      S_LEAF: begin
        // write node value, read its sibling, then walk up
        wen   = 1'b1;
        wdata = lft_r;
        if (node_r == node_t'(1)) begin
          if (second_r) begin
            second_nxt = 1'b0;
            node_nxt   = node_t'(CAPACITY) + node_t'(pos_r);
            lft_nxt    = moved_r;
          end else begin
            state_nxt = S_ROOT;
          end
        end else begin
          node_nxt  = node_r >> 1;
          raddr     = {node_r[NODE_W-1:1], ~node_r[0]};
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        // sibling is in rd_r: combine it with the written value
        greq.start = 1'b1;
        greq.a     = lft_r;
        greq.b     = rd_r;
        state_nxt  = S_GCD;
      end
      S_GCD: begin
        if (grsp.done) begin
          lft_nxt   = grsp.g;
          state_nxt = S_LEAF;
        end
      end
      S_ROOT: begin
        raddr     = node_t'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // keep the root on the read port until the result register is free
        raddr = node_t'(1);
        if (!ov_nxt) begin
          gout_nxt  = (rd_r == '0) ? val_t'(1) : rd_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      clr_r   <= clr_nxt;
    end
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    node_r   <= node_nxt;
    lft_r    <= lft_nxt;
    moved_r  <= moved_nxt;
    pos_r    <= pos_nxt;
    second_r <= second_nxt;
    st_r     <= st_nxt;
    gout_r   <= gout_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, st_r, gout_r};

endmodule

// ===== design/mgst_gcd.sv =====
// ---------------------------------------------------------------------------
// mgst_gcd
// Iterative binary GCD: one subtract-and-shift step per cycle.
// ---------------------------------------------------------------------------
module mgst_gcd import mgst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gcd_req_t req,
  output gcd_rsp_t rsp
);

  localparam int SH_W = $clog2(VAL_W + 1);

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  val_t a_r, a_nxt, b_r, b_nxt;
  logic [SH_W-1:0] k_r, k_nxt;
  val_t diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    diff     = (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);
    if (req.start) begin
      // zero operand passes the other one through
      if (req.a == '0 || req.b == '0) begin
        a_nxt    = req.a | req.b;
        b_nxt    = '0;
        k_nxt    = '0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        a_nxt    = req.a;
        b_nxt    = req.b;
        k_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      priority if (a_r == b_r) begin
        a_nxt    = a_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else begin
        // both odd: replace the larger by half the difference
        if (a_r > b_r) a_nxt = diff >> 1;
        else           b_nxt = diff >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.g    = a_r;

endmodule

// ===== design/mgst_checker.sv =====
// ---------------------------------------------------------------------------
// mgst_checker
// Port-level checks on the multiset GCD segment tree.
// ---------------------------------------------------------------------------
module mgst_checker import mgst_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // gcd_all is never zero
  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:0] != 31'd0)
    else $error("zero gcd");

  // status code in range
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:31] != 2'd3)
    else $error("bad status");

  // no new input while an item is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during work");

endmodule

bind multiset_gcd_segment_tree_top mgst_checker u_mgst_checker (.*);

// ===== dv/multiset_gcd_segment_tree_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multiset_gcd_segment_tree_top_test
// Drives insert and delete beats into the GCD multiset store and checks each
// result beat against a behavioral model of the slot array and GCD tree.
// A directed table covers the empty store, zero values and extreme values.
// A random part then fills the store past capacity and turns delete-heavy,
// under several patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module multiset_gcd_segment_tree_top_test;
  import mgst_pkg::*;

  localparam int  NODES       = 2 * CAPACITY;
  localparam int  RAND_ITEMS  = 1700;
  localparam longint MAX_CYC  = 20_000_000;
  localparam val_t VMAX       = {VAL_W{1'b1}};

  typedef struct {
    logic    mode;
    val_t    value;
    bit      typed;   // expected result given in the row
    val_t    gcd_all;
    status_t status;
  } dir_row_t;

  typedef struct {
    val_t    gcd_all;
    status_t status;
  } gcd_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // mode[0], value[31:1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // gcd_all[30:0], status[32:31]

  // model of the store
  val_t        tree_q [NODES];
  int unsigned slots_used;

  gcd_result_t result_q[$];
  int          errors = 0;
  int          beats_seen = 0;
  int          full_hits = 0;
  int          miss_hits = 0;
  int          peak_used = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  longint      cycles = 0;

  multiset_gcd_segment_tree_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Euclid on the tree's value width
  function automatic val_t euclid(val_t a, val_t b);
    val_t t;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // write one leaf and refresh its path up to the root
  function automatic void put_leaf(int unsigned slot, val_t v);
    int unsigned n;
    n = CAPACITY + slot;
    tree_q[n] = v;
    while (n > 1) begin
      n = n >> 1;
      tree_q[n] = euclid(tree_q[2*n], tree_q[2*n+1]);
    end
  endfunction

  // apply one beat to the model and return the expected result
  function automatic gcd_result_t apply_item(logic mode, val_t v);
    gcd_result_t r;
    int          pos;
    val_t        moved;
    r.status = ST_OK;
    if (mode == MODE_INS) begin
      if (slots_used >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        put_leaf(slots_used, v);
        slots_used++;
      end
    end else begin
      pos = -1;
      for (int i = 0; i < slots_used; i++) begin
        if (tree_q[CAPACITY+i] == v) begin
          pos = i;
          break;
        end
      end
      if (pos < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        moved = tree_q[CAPACITY+slots_used-1];
        put_leaf(slots_used - 1, '0);
        if (pos != slots_used - 1) put_leaf(pos, moved);
        slots_used--;
      end
    end
    r.gcd_all = (tree_q[1] == '0) ? val_t'(1) : tree_q[1];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h expected 0x%0h",
             $time, beats_seen, what, got, want);
    errors++;
  endtask

  // send one beat; valid stays high across back-to-back beats
  task automatic send_item(logic mode, val_t v, output gcd_result_t exp_r);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = apply_item(mode, v);
    result_q.push_back(exp_r);
    if (mode == MODE_INS && exp_r.status == ST_FULL) full_hits++;
    if (exp_r.status == ST_NOTFOUND) miss_hits++;
    if (slots_used > peak_used) peak_used = slots_used;
  endtask

  // values sharing factors keep the GCD interesting
  function automatic val_t pick_value();
    int unsigned roll, base;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      base = (32'd1 << $urandom_range(0, 12)) * (2 * $urandom_range(0, 3) + 1);
      return val_t'(base * $urandom_range(1, 32'h7FFF_FFFF / base));
    end else if (roll < 92) begin
      return val_t'($urandom());
    end else if (roll < 96) begin
      return '0;
    end else begin
      return ($urandom_range(0, 1) != 0) ? VMAX : val_t'(1);
    end
  endfunction

  function automatic void set_idling(int phase);
    case (phase % 4)
      0: begin send_idle = 0;  recv_idle = 0;  end
      1: begin send_idle = 66; recv_idle = 0;  end
      2: begin send_idle = 0;  recv_idle = 66; end
      default: begin send_idle = 38; recv_idle = 38; end
    endcase
  endfunction

  // result side: random stall, check each accepted beat
  always @(posedge clk) begin
    gcd_result_t want;
    if (out_tvalid && out_tready) begin
      beats_seen++;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat, gcd_all", out_tdata[30:0], 0);
      end else begin
        want = result_q.pop_front();
        if (out_tdata[30:0] !== want.gcd_all)
          report_mismatch("gcd_all", out_tdata[30:0], want.gcd_all);
        if (out_tdata[32:31] !== want.status)
          report_mismatch("status", out_tdata[32:31], want.status);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, result_q.size());
      $display("** multiset_gcd_segment_tree_top: FAILED **");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_tab[$];
    gcd_result_t exp_r;
    logic        mode;
    val_t        v;
    int unsigned roll, ins_pct;
    int          stage, n_rand, full_extra;

    for (int i = 0; i < NODES; i++) tree_q[i] = '0;
    slots_used = 0;

    dir_tab = '{
      '{MODE_DEL, val_t'(5),     1, val_t'(1), ST_NOTFOUND},  // empty store
      '{MODE_INS, val_t'(0),     1, val_t'(1), ST_OK},        // only zero: root zero
      '{MODE_DEL, val_t'(0),     1, val_t'(1), ST_OK},        // zero removed, last slot
      '{MODE_INS, VMAX,          1, VMAX,      ST_OK},
      '{MODE_INS, VMAX,          1, VMAX,      ST_OK},        // duplicate
      '{MODE_INS, val_t'(1),     1, val_t'(1), ST_OK},
      '{MODE_DEL, val_t'(1),     1, VMAX,      ST_OK},        // last slot cleared
      '{MODE_DEL, val_t'(12),    1, VMAX,      ST_NOTFOUND},
      '{MODE_DEL, VMAX,          1, VMAX,      ST_OK},        // one copy left
      '{MODE_DEL, VMAX,          1, val_t'(1), ST_OK},        // empty again
      '{MODE_INS, val_t'(12),    0, '0, ST_OK},
      '{MODE_INS, val_t'(18),    0, '0, ST_OK},
      '{MODE_INS, val_t'(30),    0, '0, ST_OK},
      '{MODE_INS, val_t'(0),     0, '0, ST_OK},
      '{MODE_DEL, val_t'(12),    0, '0, ST_OK},               // last slot moves down
      '{MODE_INS, val_t'(31'h2AAA_AAAA), 0, '0, ST_OK},
      '{MODE_INS, val_t'(31'h5555_5554), 0, '0, ST_OK},
      '{MODE_DEL, val_t'(0),     0, '0, ST_OK},
      '{MODE_DEL, val_t'(7),     0, '0, ST_OK},
      '{MODE_INS, val_t'(1 << 30), 0, '0, ST_OK}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; typed rows also cross-check the model
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].mode, dir_tab[i].value, exp_r);
      if (dir_tab[i].typed &&
          (exp_r.gcd_all !== dir_tab[i].gcd_all || exp_r.status !== dir_tab[i].status))
        report_mismatch($sformatf("table row %0d", i), exp_r.gcd_all, dir_tab[i].gcd_all);
    end

    // random: balanced, then fill past capacity, then delete-heavy
    stage = 0;
    full_extra = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS || stage < 2) begin
      set_idling(n_rand / 60);
      if (stage == 0 && n_rand >= 400) stage = 1;
      if (stage == 1 && full_extra >= 8) stage = 2;
      ins_pct = (stage == 0) ? 50 : (stage == 1) ? 92 : 30;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        mode = MODE_INS;
        v = pick_value();
      end else begin
        mode = MODE_DEL;
        if (slots_used > 0 && $urandom_range(0, 99) < 80)
          v = tree_q[CAPACITY + $urandom_range(0, slots_used - 1)];
        else
          v = pick_value();
      end
      send_item(mode, v, exp_r);
      if (exp_r.status == ST_FULL) full_extra++;
      n_rand++;
    end
    in_tvalid <= 1'b0;

    // drain, then a quiet tail
    while (result_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);

    $display("covered %0d results, peak fill %0d of %0d slots", beats_seen, peak_used,
             CAPACITY);
    $display("refused inserts %0d, deletes of absent values %0d", full_hits, miss_hits);
    if (errors == 0) begin
      $display("** multiset_gcd_segment_tree_top: PASSED **");
    end else begin
      $display("** multiset_gcd_segment_tree_top: FAILED **");
    end
    $finish;
  end

endmodule
